### src/tlnc_pkg.sv
// ----------------------------------------------------------------------------
// tlnc_pkg - shared definitions for the caret filter
// Byte codes, configuration register indexes and the structs that travel
// between the sequencer, the line counter and the top level.
// ----------------------------------------------------------------------------
package tlnc_pkg;

  // Largest supported counter size; the significant digit count fits in SIG_W.
  localparam int MAX_DIGITS = 10;
  localparam int SIG_W      = $clog2(MAX_DIGITS + 1);
  localparam int MIN_WIDTH  = 6;
  localparam int DEF_DIGITS = 8;

  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_DEL   = 8'd127;
  localparam logic [7:0] BYTE_ZERO  = 8'd48;
  localparam logic [7:0] BYTE_CARET = 8'd94;
  localparam logic [7:0] BYTE_DOLAR = 8'd36;
  localparam logic [7:0] BYTE_M     = 8'd77;
  localparam logic [7:0] BYTE_DASH  = 8'd45;
  localparam logic [7:0] BYTE_I     = 8'd73;
  localparam logic [7:0] BYTE_QUEST = 8'd63;
  localparam logic [7:0] CTRL_OFS   = 8'd64;
  localparam logic [7:0] CTRL_LIM   = 8'd32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINT   = 3'd5;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic             busy;  // serial increment in progress
    logic [SIG_W-1:0] sig;   // number of significant digits, at least one
  } cnt_status_t;

endpackage

### src/text_line_number_caret_filter_core.sv
// ----------------------------------------------------------------------------
// text_line_number_caret_filter_core - caret notation text filter
// Line numbering, blank line squeezing and ^ / M- notation for a byte stream.
// ----------------------------------------------------------------------------
// Registers: an accepted input byte is registered into the sequencer state,
// and each output beat it causes is registered in the output register.
// Flow: a new byte is taken only in the idle state with the counter idle,
// so not before the previous run has been emitted; a squeezed blank line
// emits no beat. A line number adds its beats and the serial BCD increment.
// Reset (rst_n low, synchronous): control and mode registers reset, counter set to one.
// ----------------------------------------------------------------------------
module text_line_number_caret_filter_core
  import tlnc_pkg::*;
#(
  parameter int COUNTER_DIGITS = DEF_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream, one raw text byte per beat.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] in_byte
  // Output stream, tlast marks the final byte caused by one input byte.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tlast,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [0:0]           cfg_wdata
);

  localparam int IDX_W = $clog2(COUNTER_DIGITS);

  cfg_t             cfg_r, cfg_nxt;
  cnt_status_t      cnt_status;
  logic [3:0]       cnt_digit;
  logic [IDX_W-1:0] cnt_rd_idx;
  logic             cnt_inc;

  // Mode registers. An index past the last register is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NUMBER_ALL:      cfg_nxt.number_all       = cfg_wdata[0];
        CFG_NUMBER_NONBLANK: cfg_nxt.number_nonblank  = cfg_wdata[0];
        CFG_SQUEEZE_BLANK:   cfg_nxt.squeeze_blank    = cfg_wdata[0];
        CFG_SHOW_ENDS:       cfg_nxt.show_ends        = cfg_wdata[0];
        CFG_SHOW_TABS:       cfg_nxt.show_tabs        = cfg_wdata[0];
        CFG_SHOW_NONPRINT:   cfg_nxt.show_nonprinting = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The counter holds the BCD line number and owns the shared digit adder.
  tlnc_line_counter #(
    .COUNTER_DIGITS (COUNTER_DIGITS),
    .IDX_W          (IDX_W)
  ) u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .inc_start (cnt_inc),
    .rd_idx    (cnt_rd_idx),
    .rd_digit  (cnt_digit),
    .status    (cnt_status)
  );

  // The sequencer walks through padding, digits, tab and escape bytes, and
  // owns the output register, so it can take a new byte while the last beat
  // of the previous run still waits downstream.
  tlnc_seq #(
    .COUNTER_DIGITS (COUNTER_DIGITS),
    .IDX_W          (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cnt_status (cnt_status),
    .cnt_digit  (cnt_digit),
    .cnt_rd_idx (cnt_rd_idx),
    .cnt_inc    (cnt_inc)
  );

endmodule

### src/tlnc_line_counter.sv
// ----------------------------------------------------------------------------
// tlnc_line_counter - BCD line counter with a serial incrementer
// One shared digit adder walks the counter by rotating it one digit per
// cycle; the counter saturates when every digit is nine.
// ----------------------------------------------------------------------------
module tlnc_line_counter
  import tlnc_pkg::*;
#(
  parameter int COUNTER_DIGITS = DEF_DIGITS,
  parameter int IDX_W          = $clog2(COUNTER_DIGITS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              inc_start,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [3:0]        rd_digit,
  output cnt_status_t       status
);

  logic [COUNTER_DIGITS-1:0][3:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           carry_r, carry_nxt;
  logic [IDX_W-1:0]               pos_r, pos_nxt;
  logic                           all_nine;
  logic [3:0]                     new_digit;
  logic [SIG_W-1:0]               sig;

  always_comb begin
    all_nine = 1'b1;
    sig      = SIG_W'(1);
    for (int i = 0; i < COUNTER_DIGITS; i++) begin
      if (cnt_r[i] != 4'd9) all_nine = 1'b0;
      if (cnt_r[i] != 4'd0) sig = SIG_W'(i + 1);
    end
  end

  // The digit adder always works on the lowest digit; the counter rotates
  // right so every digit passes through it once per increment.
  always_comb begin
    new_digit = cnt_r[0];
    if (carry_r) begin
      new_digit = (cnt_r[0] >= 4'd9) ? 4'd0 : cnt_r[0] + 4'd1;
    end
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    carry_nxt = carry_r;
    pos_nxt   = pos_r;
    if (busy_r) begin
      cnt_nxt   = {new_digit, cnt_r[COUNTER_DIGITS-1:1]};
      carry_nxt = carry_r && (cnt_r[0] >= 4'd9);
      pos_nxt   = pos_r + IDX_W'(1);
      if (pos_r == IDX_W'(COUNTER_DIGITS - 1)) busy_nxt = 1'b0;
    end else if (inc_start && !all_nine) begin
      busy_nxt  = 1'b1;
      carry_nxt = 1'b1;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= (4 * COUNTER_DIGITS)'(1);
      busy_r  <= 1'b0;
      carry_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      carry_r <= carry_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign rd_digit    = cnt_r[rd_idx];
  assign status.busy = busy_r;
  assign status.sig  = sig;

endmodule

### src/tlnc_seq.sv
// ----------------------------------------------------------------------------
// tlnc_seq - byte sequencer and output register
// Decides the run of bytes for each accepted input byte and emits them one
// per cycle unless stalled: padding, number digits, tab, then escape bytes.
// ----------------------------------------------------------------------------
module tlnc_seq
  import tlnc_pkg::*;
#(
  parameter int COUNTER_DIGITS = DEF_DIGITS,
  parameter int IDX_W          = $clog2(COUNTER_DIGITS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  input  cnt_status_t      cnt_status,
  input  logic [3:0]       cnt_digit,
  output logic [IDX_W-1:0] cnt_rd_idx,
  output logic             cnt_inc
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPACE = 3'd1;
  localparam logic [2:0] S_DIGIT = 3'd2;
  localparam logic [2:0] S_TAB   = 3'd3;
  localparam logic [2:0] S_ESC   = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [3:0][7:0] esc_r, esc_nxt;
  logic [1:0]      esc_left_r, esc_left_nxt;
  logic [2:0]      spc_r, spc_nxt;
  logic [IDX_W-1:0] dig_r, dig_nxt;
  logic            at_line_start_r, at_line_start_nxt;
  logic            prev_blank_r, prev_blank_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;

  logic            adv;
  logic            accept;
  logic            blank;
  logic            squeezed;
  logic            do_num;
  logic [3:0][7:0] esc_bytes;
  logic [1:0]      esc_last;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_last;

  // Escape expansion of one raw byte; byte 0 goes out first.
  always_comb begin
    esc_bytes = {4{in_tdata}};
    esc_last  = 2'd0;
    if (cfg.show_tabs && in_tdata == BYTE_TAB) begin
      esc_bytes[0] = BYTE_CARET;
      esc_bytes[1] = BYTE_I;
      esc_last     = 2'd1;
    end else if (cfg.show_ends && in_tdata == BYTE_NL) begin
      esc_bytes[0] = BYTE_DOLAR;
      esc_bytes[1] = BYTE_NL;
      esc_last     = 2'd1;
    end else if (cfg.show_nonprinting) begin
      if (in_tdata[7]) begin
        esc_bytes[0] = BYTE_M;
        esc_bytes[1] = BYTE_DASH;
        if ({1'b0, in_tdata[6:0]} < CTRL_LIM) begin
          esc_bytes[2] = BYTE_CARET;
          esc_bytes[3] = {1'b0, in_tdata[6:0]} + CTRL_OFS;
          esc_last     = 2'd3;
        end else begin
          esc_bytes[2] = {1'b0, in_tdata[6:0]};
          esc_last     = 2'd2;
        end
      end else if (in_tdata < CTRL_LIM && in_tdata != BYTE_TAB && in_tdata != BYTE_NL) begin
        esc_bytes[0] = BYTE_CARET;
        esc_bytes[1] = in_tdata + CTRL_OFS;
        esc_last     = 2'd1;
      end else if (in_tdata == BYTE_DEL) begin
        esc_bytes[0] = BYTE_CARET;
        esc_bytes[1] = BYTE_QUEST;
        esc_last     = 2'd1;
      end
    end
  end

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && !cnt_status.busy;
  assign accept     = in_tvalid && in_tready;
  assign blank      = (in_tdata == BYTE_NL);
  assign squeezed   = at_line_start_r && cfg.squeeze_blank && blank && prev_blank_r;
  assign do_num     = at_line_start_r &&
                      (cfg.number_nonblank ? !blank : cfg.number_all);
  assign cnt_rd_idx = dig_r;

  always_comb begin
    state_nxt         = state_r;
    esc_nxt           = esc_r;
    esc_left_nxt      = esc_left_r;
    spc_nxt           = spc_r;
    dig_nxt           = dig_r;
    at_line_start_nxt = at_line_start_r;
    prev_blank_nxt    = prev_blank_r;
    emit              = 1'b0;
    emit_byte         = esc_r[0];
    emit_last         = 1'b0;
    cnt_inc           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (at_line_start_r) prev_blank_nxt = blank;
          at_line_start_nxt = blank;
          esc_nxt      = esc_bytes;
          esc_left_nxt = esc_last;
          spc_nxt      = 3'(MIN_WIDTH) - 3'(cnt_status.sig);
          dig_nxt      = IDX_W'(cnt_status.sig - SIG_W'(1));
          if (squeezed) begin
            state_nxt = S_IDLE;
          end else if (do_num) begin
            state_nxt = (cnt_status.sig < SIG_W'(MIN_WIDTH)) ? S_SPACE : S_DIGIT;
          end else begin
            state_nxt = S_ESC;
          end
        end
      end
      S_SPACE: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = BYTE_SPACE;
          spc_nxt   = spc_r - 3'd1;
          if (spc_r == 3'd1) state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = BYTE_ZERO + {4'd0, cnt_digit};
          if (dig_r == '0) begin
            state_nxt = S_TAB;
          end else begin
            dig_nxt = dig_r - IDX_W'(1);
          end
        end
      end
      S_TAB: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = BYTE_TAB;
          cnt_inc   = 1'b1;
          state_nxt = S_ESC;
        end
      end
      S_ESC: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = esc_r[0];
          emit_last = (esc_left_r == 2'd0);
          esc_nxt   = {8'd0, esc_r[3:1]};
          if (esc_left_r == 2'd0) begin
            state_nxt = S_IDLE;
          end else begin
            esc_left_nxt = esc_left_r - 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      at_line_start_r <= 1'b1;
      prev_blank_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      at_line_start_r <= at_line_start_nxt;
      prev_blank_r    <= prev_blank_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    esc_r      <= esc_nxt;
    esc_left_r <= esc_left_nxt;
    spc_r      <= spc_nxt;
    dig_r      <= dig_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // The counter must not move while its digits are being printed.
  a_no_read_while_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_status.busy |-> (state_r != S_SPACE && state_r != S_DIGIT))
    else $error("line counter changed during number output");

  a_tab_then_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAB && adv) |=> (state_r == S_ESC && out_tvalid && !out_tlast))
    else $error("tab after line number not followed by escape bytes");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ESC && adv && esc_left_r == 2'd0) |=> (state_r == S_IDLE && out_tlast))
    else $error("run did not end on its last beat");
`endif

endmodule

### bench/text_line_number_caret_filter_checker.sv
// ----------------------------------------------------------------------------
// text_line_number_caret_filter_checker - scoreboard for the caret filter
// Watches the configuration port and both streams. It formats every accepted
// input byte on its own copy of the filter state and compares each output
// beat with the oldest formatted byte still owed.
// ----------------------------------------------------------------------------
module text_line_number_caret_filter_checker
  import tlnc_pkg::*;
#(
  parameter int COUNTER_DIGITS = DEF_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [0:0]           cfg_wdata,
  output int                   fail_count,
  output int                   beats_owed
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  cfg_t                        settings;
  logic                        at_line_start;
  logic                        prev_line_blank;
  logic [4*COUNTER_DIGITS-1:0] line_number_bcd;
  text_beat_t                  owed_beats[$];
  int                          fails = 0;

  initial fail_count = 0;
  initial beats_owed = 0;

  function automatic void put_byte(input logic [7:0] b);
    owed_beats.push_back('{data: b, last: 1'b0});
  endfunction

  // Right-justified to MIN_WIDTH columns, wider numbers printed in full.
  task automatic put_line_number();
    int sig;
    int i;
    sig = 1;
    for (i = 0; i < COUNTER_DIGITS; i++)
      if (line_number_bcd[4*i +: 4] != 4'd0) sig = i + 1;
    for (i = sig; i < MIN_WIDTH; i++) put_byte(BYTE_SPACE);
    for (i = sig; i > 0; i--) put_byte(BYTE_ZERO + 8'(line_number_bcd[4*(i-1) +: 4]));
    put_byte(BYTE_TAB);
  endtask

  // Decimal increment that sticks once every digit is nine.
  task automatic bump_line_number();
    logic all_nine;
    logic carry;
    int   i;
    all_nine = 1'b1;
    for (i = 0; i < COUNTER_DIGITS; i++)
      if (line_number_bcd[4*i +: 4] != 4'd9) all_nine = 1'b0;
    if (!all_nine) begin
      carry = 1'b1;
      for (i = 0; i < COUNTER_DIGITS; i++) begin
        if (carry) begin
          if (line_number_bcd[4*i +: 4] >= 4'd9) begin
            line_number_bcd[4*i +: 4] = 4'd0;
          end else begin
            line_number_bcd[4*i +: 4] = line_number_bcd[4*i +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic format_text_byte(input logic [7:0] b);
    logic blank;
    logic was_blank;
    if (at_line_start) begin
      blank           = (b == BYTE_NL);
      was_blank       = prev_line_blank;
      prev_line_blank = blank;
      // A repeated blank line vanishes and the next byte still opens a line.
      if (settings.squeeze_blank && blank && was_blank) return;
      if (settings.number_nonblank) begin
        if (!blank) begin
          put_line_number();
          bump_line_number();
        end
      end else if (settings.number_all) begin
        put_line_number();
        bump_line_number();
      end
    end
    at_line_start = (b == BYTE_NL);

    if (settings.show_tabs && b == BYTE_TAB) begin
      put_byte(BYTE_CARET);
      put_byte(BYTE_I);
    end else if (settings.show_ends && b == BYTE_NL) begin
      put_byte(BYTE_DOLAR);
      put_byte(BYTE_NL);
    end else if (settings.show_nonprinting) begin
      if (b >= 8'd128) begin
        put_byte(BYTE_M);
        put_byte(BYTE_DASH);
        if (b < 8'd128 + CTRL_LIM) begin
          put_byte(BYTE_CARET);
          put_byte(b - 8'd128 + CTRL_OFS);
        end else begin
          put_byte(b - 8'd128);
        end
      end else if (b < CTRL_LIM && b != BYTE_TAB && b != BYTE_NL) begin
        put_byte(BYTE_CARET);
        put_byte(b + CTRL_OFS);
      end else if (b < BYTE_DEL) begin
        put_byte(b);
      end else begin
        put_byte(BYTE_CARET);
        put_byte(BYTE_QUEST);
      end
    end else begin
      put_byte(b);
    end
    owed_beats[owed_beats.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    text_beat_t want;
    if (!rst_n) begin
      settings        = '0;
      at_line_start   = 1'b1;
      prev_line_blank = 1'b0;
      line_number_bcd = 1;
      owed_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_NUMBER_ALL:      settings.number_all       = cfg_wdata[0];
          CFG_NUMBER_NONBLANK: settings.number_nonblank  = cfg_wdata[0];
          CFG_SQUEEZE_BLANK:   settings.squeeze_blank    = cfg_wdata[0];
          CFG_SHOW_ENDS:       settings.show_ends        = cfg_wdata[0];
          CFG_SHOW_TABS:       settings.show_tabs        = cfg_wdata[0];
          CFG_SHOW_NONPRINT:   settings.show_nonprinting = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) format_text_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (owed_beats.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none, actual data %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = owed_beats.pop_front();
          if (want.data !== out_tdata || want.last !== out_tlast) begin
            fails++;
            $display("%0t: mismatch, expected data %h last %b, actual data %h last %b",
                     $time, want.data, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
    fail_count <= fails;
    beats_owed <= owed_beats.size();
  end

endmodule

### bench/tb_text_line_number_caret_filter_core.sv
// ----------------------------------------------------------------------------
// tb_text_line_number_caret_filter_core - testbench for the caret filter
// Drives short directed runs over the byte extremes and every escape form,
// then random line-structured text under random register settings, with
// random stalls on both streams, none in the last third of the phases. A
// separate checker formats the stream itself and compares every output beat.
// ----------------------------------------------------------------------------
module tb_text_line_number_caret_filter_core;
  import tlnc_pkg::*;

  localparam int LINE_DIGITS   = DEF_DIGITS;
  // Quiet cycles tolerated before the run is declared hung. A single input
  // byte costs at most 13 output beats plus the serial counter update, and
  // each beat may sit behind a receiver stall, so this is far above any
  // correct run.
  localparam int QUIET_LIMIT   = 4000;
  // Cycles let pass after the last owed beat before registers change: the
  // counter update after a line number, or a squeezed line, may still be
  // in flight.
  localparam int SETTLE_CYCLES = LINE_DIGITS + 6;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 12;
  localparam int BLANK_PCT     = 30;

  // Register indexes past the end of the list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Byte extremes and every escape form: printable, tab, NUL, last control,
  // DEL, first high byte, last high control, first high printable, 255, and
  // a newline to close the line.
  localparam logic [7:0] ESCAPE_BYTES[10] = '{8'h41, 8'h09, 8'h00, 8'h1f, 8'h7f,
                                              8'h80, 8'h9f, 8'ha0, 8'hff, 8'h0a};
  // Blank line runs: the second and third blank lines are squeezed away, a
  // line opening with a tab, then a plain line, then a single blank line.
  localparam logic [7:0] BLANK_BYTES[8]   = '{8'h0a, 8'h0a, 8'h0a, 8'h09,
                                              8'h0a, 8'h78, 8'h0a, 8'h0a};
  localparam logic [7:0] PLAIN_BYTES[3]   = '{8'h00, 8'hff, 8'h0a};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;   // [7:0] in_byte
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;          // [7:0] out_byte
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_NUMBER_ALL;
  logic [0:0]           cfg_wdata = 1'b0;

  int fail_count;
  int beats_owed;
  int quiet_cycles = 0;

  // Percent of cycles in which each side holds back; changed between phases.
  int send_idle_pct = 38;
  int recv_idle_pct = 70;

  initial begin
    forever #4 clk = ~clk;
  end

  text_line_number_caret_filter_core #(
    .COUNTER_DIGITS(LINE_DIGITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  text_line_number_caret_filter_checker #(
    .COUNTER_DIGITS(LINE_DIGITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .beats_owed (beats_owed)
  );

  // The receiver decides anew every cycle whether it takes a beat, so stalls
  // can land on any beat of a run, including the line number digits.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hang detection: any accepted beat or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte and holds it until the beat is taken. Afterwards the
  // sender may stay idle at random. Valid is only lowered inside the
  // idle loop, so it is never dropped and raised in the same time step.
  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  // Waits until every owed beat has come out, then lets the block finish any
  // trailing work that produces no beat. The owed count is first read only
  // once the checker has counted the run of the last input beat.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register, plus one write to a spare index that must leave
  // the settings alone.
  task automatic write_settings(input cfg_t s);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NUMBER_ALL;
    cfg_wdata <= s.number_all;
    @(posedge clk);
    cfg_idx   <= CFG_NUMBER_NONBLANK;
    cfg_wdata <= s.number_nonblank;
    @(posedge clk);
    cfg_idx   <= CFG_SQUEEZE_BLANK;
    cfg_wdata <= s.squeeze_blank;
    @(posedge clk);
    cfg_idx   <= CFG_SHOW_ENDS;
    cfg_wdata <= s.show_ends;
    @(posedge clk);
    cfg_idx   <= CFG_SHOW_TABS;
    cfg_wdata <= s.show_tabs;
    @(posedge clk);
    cfg_idx   <= CFG_SHOW_NONPRINT;
    cfg_wdata <= s.show_nonprinting;
    @(posedge clk);
    cfg_idx   <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_wdata <= 1'($urandom_range(0, 1));
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Line content: mostly printable text, with tabs and a share of arbitrary
  // bytes so that control and high bytes, and every data bit, show up.
  function automatic logic [7:0] pick_text_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return BYTE_TAB;
    if (roll < 40) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  initial begin : stimulus
    int   phase;
    int   sent;
    int   len;
    int   i;
    cfg_t pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every escape form with numbering, ends and tabs shown.
    write_settings('{number_all: 1'b1, number_nonblank: 1'b0, squeeze_blank: 1'b0,
                     show_ends: 1'b1, show_tabs: 1'b1, show_nonprinting: 1'b1});
    foreach (ESCAPE_BYTES[i]) send_byte(ESCAPE_BYTES[i]);
    settle();

    // Directed: non-blank numbering overriding number_all, squeezing, and
    // tab and newline passing through raw with only show_nonprinting set.
    write_settings('{number_all: 1'b1, number_nonblank: 1'b1, squeeze_blank: 1'b1,
                     show_ends: 1'b0, show_tabs: 1'b0, show_nonprinting: 1'b1});
    foreach (BLANK_BYTES[i]) send_byte(BLANK_BYTES[i]);
    settle();

    // Directed: every option off, bytes go through untouched.
    write_settings('0);
    foreach (PLAIN_BYTES[i]) send_byte(PLAIN_BYTES[i]);
    settle();

    // Random text made of whole lines, with runs of blank lines so that
    // squeezing and the line-start logic get real work.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 38;
      end else if (phase == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = (phase == 0) ? cfg_t'('1) : cfg_t'($urandom_range(0, 63));
      settle();
      write_settings(pick);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < BLANK_PCT) begin
          send_byte(BYTE_NL);
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (i = 0; i < len; i++) send_byte(pick_text_byte());
          send_byte(BYTE_NL);
          sent += len + 1;
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
